// ----- rtl/gfba_pkg.sv -----
// ----------------------------------------------------------------------------
// gfba_pkg
// Shared types and codes of the grouped free-block allocator.
// ----------------------------------------------------------------------------
package gfba_pkg;

  localparam int BLK_PORT_W = 10;
  localparam int CNT_PORT_W = 5;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

  typedef enum logic [2:0] {
    S_INIT = 3'b001,
    S_IDLE = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  typedef struct packed {
    logic wr;
    logic done;
  } walk_ctl_t;

endpackage

// ----- rtl/gfba_if.sv -----
// ----------------------------------------------------------------------------
// gfba_req_if / gfba_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface gfba_req_if;
  import gfba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [BLK_PORT_W-1:0] release_block;
  modport source (output valid, output op, output release_block, input ready);
  modport sink (input valid, input op, input release_block, output ready);
endinterface

interface gfba_rsp_if;
  import gfba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [BLK_PORT_W-1:0] granted_block;
  logic                  status;
  logic [CNT_PORT_W-1:0] stack_count;
  modport source (output valid, output granted_block, output status, output stack_count,
                  input ready);
  modport sink (input valid, input granted_block, input status, input stack_count,
                output ready);
endinterface

// ----- rtl/gfba_link_mem.sv -----
// ----------------------------------------------------------------------------
// gfba_link_mem
// Link-group memory: one row per block, one write and one registered read.
// ----------------------------------------------------------------------------
module gfba_link_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int WIDTH = 165
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gfba_init_walk.sv -----
// ----------------------------------------------------------------------------
// gfba_init_walk
// Post-reset walk that writes the formatted chain into the link memory.
// ----------------------------------------------------------------------------
module gfba_init_walk #(
  parameter int GROUP      = 16,
  parameter int NUM_BLOCKS = 1024,
  parameter int BW         = 10,
  parameter int CW         = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  output gfba_pkg::walk_ctl_t     ctl,
  output logic [BW-1:0]           addr,
  output logic [CW+GROUP*BW-1:0]  row
);
  import gfba_pkg::*;

  localparam int DW = (GROUP > 2) ? $clog2(GROUP) : 1;

  logic [BW-1:0] idx;
  logic [DW-1:0] gpos;
  logic          busy;
  logic [BW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          chain;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      gpos <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      idx  <= idx + 1'b1;
      gpos <= (gpos == DW'(GROUP - 1)) ? '0 : gpos + 1'b1;
      if (idx == BW'(NUM_BLOCKS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Entries are stored by depth: depth d reloads to stack depth d.
  always_comb begin
    rem   = BW'(NUM_BLOCKS - 1) - idx;
    chain = (gpos == DW'(GROUP - 1));
    if (!chain) begin
      cnt = '0;
    end else if (32'(rem) >= GROUP) begin
      cnt = CW'(GROUP);
    end else begin
      cnt = CW'(rem);
    end
    row[GROUP*BW +: CW] = cnt;
    for (int d = 0; d < GROUP; d++) begin
      row[d*BW +: BW] = BW'(32'(idx) + 32'(cnt) - d);
    end
  end

  assign addr     = idx;
  assign ctl.wr   = busy;
  assign ctl.done = !busy;

endmodule

// ----- rtl/grouped_free_block_allocator.sv -----
// ----------------------------------------------------------------------------
// grouped_free_block_allocator
// Free-block allocator with a grouped free list: a stack of GROUP free
// numbers whose deepest entry links to a block holding the next group.
//
//   channel  dir  payload                               accepted when
//   req      in   op, release_block                     req.valid && req.ready
//   rsp      out  granted_block, status, stack_count    rsp.valid && rsp.ready
//
// For each item, the accept cycle reads the link row of the current
// deepest stack entry; the execute state then updates the stack and writes
// the link memory on a spill or an empty-stack release.
// After reset an initialization walk lays out the chain;
// req.ready stays low during it.
// A result waits in the output register; a new item is taken meanwhile and
// holds in the execute state until the register is free.
// ----------------------------------------------------------------------------
module grouped_free_block_allocator #(
  parameter int GROUP      = 16,
  parameter int NUM_BLOCKS = 1024
) (
  input logic       clk,
  input logic       rst,
  gfba_req_if.sink  req,
  gfba_rsp_if.source rsp
);
  import gfba_pkg::*;

  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int CW  = $clog2(GROUP + 1);
  localparam int DW  = (GROUP > 2) ? $clog2(GROUP) : 1;
  localparam int RW  = CW + GROUP * BW;
  localparam int NB0 = (GROUP < NUM_BLOCKS) ? GROUP : NUM_BLOCKS;

  state_t                state;
  logic [BW-1:0]         stack      [GROUP];
  logic [BW-1:0]         stack_next [GROUP];
  logic [CW-1:0]         fill;
  logic [CW-1:0]         fill_next;
  logic                  op_q;
  logic [BLK_PORT_W-1:0] blk_q;

  logic                  out_valid;
  logic [BLK_PORT_W-1:0] out_granted;
  logic                  out_status;
  logic [CNT_PORT_W-1:0] out_count;

  walk_ctl_t             walk_ctl;
  logic [BW-1:0]         walk_addr;
  logic [RW-1:0]         walk_row;

  logic                  mem_we;
  logic [BW-1:0]         mem_waddr;
  logic [RW-1:0]         mem_wdata;
  logic                  rd_en;
  logic [RW-1:0]         rdata;

  logic                  accept;
  logic                  fire;
  logic                  rel_ok;
  logic                  ex_we;
  logic [RW-1:0]         ex_wdata;
  logic [BW-1:0]         granted;
  logic                  status;
  logic [RW-CW-1:0]      stack_row;
  logic [CW-1:0]         fill_dec;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign fire      = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign rd_en     = accept;

  gfba_init_walk #(
    .GROUP      (GROUP),
    .NUM_BLOCKS (NUM_BLOCKS),
    .BW         (BW),
    .CW         (CW)
  ) u_walk (
    .clk  (clk),
    .rst  (rst),
    .ctl  (walk_ctl),
    .addr (walk_addr),
    .row  (walk_row)
  );

  assign mem_we    = walk_ctl.wr || ex_we;
  assign mem_waddr = walk_ctl.wr ? walk_addr : BW'(blk_q);
  assign mem_wdata = walk_ctl.wr ? walk_row : ex_wdata;

  gfba_link_mem #(
    .DEPTH (NUM_BLOCKS),
    .AW    (BW),
    .WIDTH (RW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (stack[0]),
    .rdata (rdata)
  );

  always_comb begin
    for (int d = 0; d < GROUP; d++) begin
      stack_row[d*BW +: BW] = stack[d];
    end
    fill_dec   = fill - 1'b1;
    rel_ok     = (32'(blk_q) < NUM_BLOCKS);
    stack_next = stack;
    fill_next  = fill;
    granted    = '0;
    status     = ST_DONE;
    ex_we      = 1'b0;
    ex_wdata   = {CW'(GROUP), stack_row};
    unique case (op_q)
      OP_ALLOC: begin
        if (fill == '0) begin
          status = ST_EMPTY;
        end else begin
          granted = stack[DW'(fill_dec)];
          if (fill == CW'(1)) begin
            for (int d = 0; d < GROUP; d++) begin
              stack_next[d] = rdata[d*BW +: BW];
            end
            fill_next = rdata[GROUP*BW +: CW];
          end else begin
            fill_next = fill_dec;
          end
        end
      end
      OP_RELEASE: begin
        if (rel_ok) begin
          if (fill == CW'(GROUP)) begin
            ex_we         = fire;
            stack_next[0] = BW'(blk_q);
            fill_next     = CW'(1);
          end else if (fill == '0) begin
            ex_we         = fire;
            ex_wdata      = {{CW{1'b0}}, stack_row};
            stack_next[0] = BW'(blk_q);
            fill_next     = CW'(1);
          end else begin
            stack_next[DW'(fill)] = BW'(blk_q);
            fill_next             = fill + 1'b1;
          end
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      fill  <= CW'(NB0);
      for (int d = 0; d < GROUP; d++) begin
        stack[d] <= BW'(NB0 - 1 - d);
      end
    end else begin
      unique case (state)
        S_INIT: begin
          if (walk_ctl.done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q  <= req.op;
            blk_q <= req.release_block;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            stack <= stack_next;
            fill  <= fill_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_granted <= BLK_PORT_W'(granted);
      out_status  <= status;
      out_count   <= CNT_PORT_W'(fill_next);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.granted_block = out_granted;
  assign rsp.status        = out_status;
  assign rsp.stack_count   = out_count;

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted item did not move to execution");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result appeared without an executed item");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !rd_en)
    else $error("link memory written while a link row is read");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp.stack_count == CNT_PORT_W'(fill))
    else $error("reported stack count differs from stack fill");
`endif

endmodule
